// File: rtl/lrhm_pkg.sv
// ----------------------------------------------------------------------------
// lrhm_pkg: shared types and constants of the load ratio hysteresis monitor
// Holds register indexes, report codes, the ppm scale and the records that
// travel between the front, the back and the result queue.
// ----------------------------------------------------------------------------
package lrhm_pkg;

    localparam int unsigned SAMPLE_W = 64;
    localparam int unsigned RATIO_W  = 20;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned HALF_W   = SAMPLE_W / 2;
    localparam int unsigned PART_W   = HALF_W + RATIO_W;
    localparam int unsigned PROD_W   = SAMPLE_W + RATIO_W;

    localparam logic [RATIO_W-1:0] PPM_SCALE      = 20'd1000000;
    localparam logic [RATIO_W-1:0] RATIO_RESET    = 20'd980000;
    localparam logic [COUNT_W-1:0] WINDOW_RESET   = 8'd5;
    localparam logic [COUNT_W-1:0] HIGH_THR_RESET = 8'd4;
    localparam logic [COUNT_W-1:0] LOW_THR_RESET  = 8'd0;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE   = 3'd0,
        REG_RATIO    = 3'd1,
        REG_WINDOW   = 3'd2,
        REG_HIGH_THR = 3'd3,
        REG_LOW_THR  = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        REPORT_NONE = 2'd0,
        REPORT_HIGH = 2'd1,
        REPORT_LOW  = 2'd2
    } report_t;

    // Live configuration seen by the front and the back.
    typedef struct packed {
        logic               enable;
        logic [RATIO_W-1:0] busy_ratio_ppm;
        logic [COUNT_W-1:0] window_ticks;
        logic [COUNT_W-1:0] high_count_threshold;
        logic [COUNT_W-1:0] low_count_threshold;
    } cfg_t;

    // One classified tick handed from the front to the back.
    typedef struct packed {
        logic enabled;
        logic was_high;
    } tick_class_t;

    // One result beat.
    typedef struct packed {
        report_t report;
        logic    tick_was_high;
        logic    window_closed;
    } result_t;

endpackage

// File: rtl/lrhm_fifo.sv
// ----------------------------------------------------------------------------
// lrhm_fifo: small register queue
// First-in first-out store with the head visible combinationally.
// ----------------------------------------------------------------------------
module lrhm_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == FULL_COUNT);
    assign empty     = (count_reg == '0);
    assign head_data = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Upstream credit control must never offer a beat to a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("lrhm_fifo: push while full");

endmodule

// File: rtl/lrhm_front.sv
// ----------------------------------------------------------------------------
// lrhm_front: sample intake and tick classification
// Forms the counter deltas, multiplies them in 32-bit halves and compares
// the exact products to mark each tick as high-load or not.
// ----------------------------------------------------------------------------
module lrhm_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [lrhm_pkg::SAMPLE_W-1:0]     total_time_sample,
    input  logic [lrhm_pkg::SAMPLE_W-1:0]     busy_time_sample,
    input  lrhm_pkg::cfg_t                    cfg,
    output logic                              class_valid,
    output lrhm_pkg::tick_class_t             class_data
);

    localparam int unsigned SW = lrhm_pkg::SAMPLE_W;
    localparam int unsigned HW = lrhm_pkg::HALF_W;
    localparam int unsigned PW = lrhm_pkg::PART_W;
    localparam int unsigned QW = lrhm_pkg::PROD_W;
    localparam int unsigned RW = lrhm_pkg::RATIO_W;

    // Samples of the last enabled tick.
    logic [SW-1:0] prev_total_reg, prev_busy_reg;

    // Stage 1: deltas.
    logic          valid1_reg, en1_reg;
    logic [SW-1:0] total_delta1_reg, busy_delta1_reg;

    // Stage 2: partial products.
    logic          valid2_reg, en2_reg, nonzero2_reg;
    logic [PW-1:0] busy_lo2_reg, busy_hi2_reg, total_lo2_reg, total_hi2_reg;

    // Stage 3: full products.
    logic          valid3_reg, en3_reg, nonzero3_reg;
    logic [QW-1:0] busy_prod3_reg, total_prod3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_total_reg <= '0;
            prev_busy_reg  <= '0;
            valid1_reg     <= 1'b0;
            valid2_reg     <= 1'b0;
            valid3_reg     <= 1'b0;
        end
        else
        begin
            valid1_reg <= accept;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            if (accept && cfg.enable)
            begin
                prev_total_reg <= total_time_sample;
                prev_busy_reg  <= busy_time_sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            en1_reg          <= cfg.enable;
            total_delta1_reg <= total_time_sample - prev_total_reg;
            busy_delta1_reg  <= busy_time_sample - prev_busy_reg;
        end

        en2_reg       <= en1_reg;
        nonzero2_reg  <= (total_delta1_reg != '0);
        busy_lo2_reg  <= {{RW{1'b0}}, busy_delta1_reg[HW-1:0]}
                         * {{HW{1'b0}}, lrhm_pkg::PPM_SCALE};
        busy_hi2_reg  <= {{RW{1'b0}}, busy_delta1_reg[SW-1:HW]}
                         * {{HW{1'b0}}, lrhm_pkg::PPM_SCALE};
        total_lo2_reg <= {{RW{1'b0}}, total_delta1_reg[HW-1:0]}
                         * {{HW{1'b0}}, cfg.busy_ratio_ppm};
        total_hi2_reg <= {{RW{1'b0}}, total_delta1_reg[SW-1:HW]}
                         * {{HW{1'b0}}, cfg.busy_ratio_ppm};

        en3_reg         <= en2_reg;
        nonzero3_reg    <= nonzero2_reg;
        busy_prod3_reg  <= {busy_hi2_reg, {HW{1'b0}}} + {{HW{1'b0}}, busy_lo2_reg};
        total_prod3_reg <= {total_hi2_reg, {HW{1'b0}}} + {{HW{1'b0}}, total_lo2_reg};
    end

    assign class_valid         = valid3_reg;
    assign class_data.enabled  = en3_reg;
    assign class_data.was_high = en3_reg && nonzero3_reg
                                 && (busy_prod3_reg >= total_prod3_reg);

endmodule

// File: rtl/lrhm_back.sv
// ----------------------------------------------------------------------------
// lrhm_back: window counting and hysteresis reporting
// Counts classified ticks per window and emits a report only when the
// decision changes from the last one.
// ----------------------------------------------------------------------------
module lrhm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrhm_pkg::cfg_t        cfg,
    input  logic                  window_clear,
    input  logic                  tick_valid,
    input  lrhm_pkg::tick_class_t tick,
    output lrhm_pkg::result_t     result
);

    localparam int unsigned CW = lrhm_pkg::COUNT_W;

    logic [CW-1:0] tick_count_reg, tick_count_next;
    logic [CW-1:0] high_count_reg, high_count_next;
    logic          last_high_reg, last_high_next;
    logic [CW-1:0] high_count_inc, tick_count_inc;

    always_comb
    begin
        tick_count_next      = tick_count_reg;
        high_count_next      = high_count_reg;
        last_high_next       = last_high_reg;
        result.report        = lrhm_pkg::REPORT_NONE;
        result.tick_was_high = 1'b0;
        result.window_closed = 1'b0;

        high_count_inc = (tick.was_high && (high_count_reg != lrhm_pkg::COUNT_MAX))
                         ? high_count_reg + 1'b1 : high_count_reg;
        tick_count_inc = tick_count_reg + 1'b1;

        if (window_clear)
        begin
            tick_count_next = '0;
            high_count_next = '0;
        end
        else if (tick_valid)
        begin
            if (!tick.enabled)
            begin
                tick_count_next = '0;
                high_count_next = '0;
            end
            else
            begin
                result.tick_was_high = tick.was_high;
                tick_count_next      = tick_count_inc;
                high_count_next      = high_count_inc;
                if (tick_count_inc == cfg.window_ticks)
                begin
                    result.window_closed = 1'b1;
                    if ((high_count_inc >= cfg.high_count_threshold) && !last_high_reg)
                    begin
                        result.report  = lrhm_pkg::REPORT_HIGH;
                        last_high_next = 1'b1;
                    end
                    else if ((high_count_inc == cfg.low_count_threshold) && last_high_reg)
                    begin
                        result.report  = lrhm_pkg::REPORT_LOW;
                        last_high_next = 1'b0;
                    end
                    tick_count_next = '0;
                    high_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            high_count_reg <= '0;
            last_high_reg  <= 1'b0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            high_count_reg <= high_count_next;
            last_high_reg  <= last_high_next;
        end
    end

    // A report can only come out of a window that just closed.
    a_report_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && (result.report != lrhm_pkg::REPORT_NONE)) |-> result.window_closed)
        else $error("lrhm_back: report outside window close");

    // A HIGH report flips the hysteresis state to high on the next cycle.
    a_high_sets_state: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !window_clear && (result.report == lrhm_pkg::REPORT_HIGH))
        |=> last_high_reg)
        else $error("lrhm_back: HIGH report did not set state");

endmodule

// File: rtl/load_ratio_hysteresis_monitor_top.sv
// ----------------------------------------------------------------------------
// load_ratio_hysteresis_monitor_top: load ratio hysteresis monitor
// Takes cumulative total and busy time counters per tick, marks high-load
// ticks and reports HIGH or LOW at window ends when the decision changes.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                   Payload
//  -------   -------------------------   -----------------------------------
//  input     push / full                 total_time_sample, busy_time_sample
//  result    empty / pop                 report, tick_was_high, window_closed
//  config    cfg_we (no wait)            cfg_index, cfg_data
//
// The accepting edge registers the deltas; the partial products, their sum, the
// classification queue and the window logic are then registered in that order.
// At most QUEUE_DEPTH beats are in flight and full marks that cap; a depth of six
// or more sustains one beat per cycle while the result side keeps popping. Reset
// clears the window counters, previous samples and queues and loads the register
// reset values. A stalled result side backs up into full; no beat is lost.
// ----------------------------------------------------------------------------
module load_ratio_hysteresis_monitor_top #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input queue side.
    input  logic                                push,
    output logic                                full,
    input  logic [lrhm_pkg::SAMPLE_W-1:0]       total_time_sample,
    input  logic [lrhm_pkg::SAMPLE_W-1:0]       busy_time_sample,
    // Result queue side.
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          report,
    output logic                                tick_was_high,
    output logic                                window_closed,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [lrhm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lrhm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CREDIT_MAX = CNT_W'(QUEUE_DEPTH);
    localparam int unsigned CLASS_W  = $bits(lrhm_pkg::tick_class_t);
    localparam int unsigned RESULT_W = $bits(lrhm_pkg::result_t);
    localparam int unsigned CW = lrhm_pkg::COUNT_W;

    // Configuration registers.
    lrhm_pkg::cfg_t cfg_reg;
    logic           window_clear;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable               <= 1'b0;
            cfg_reg.busy_ratio_ppm       <= lrhm_pkg::RATIO_RESET;
            cfg_reg.window_ticks         <= lrhm_pkg::WINDOW_RESET;
            cfg_reg.high_count_threshold <= lrhm_pkg::HIGH_THR_RESET;
            cfg_reg.low_count_threshold  <= lrhm_pkg::LOW_THR_RESET;
        end
        else if (cfg_we)
        begin
            case (lrhm_pkg::reg_index_t'(cfg_index))
                lrhm_pkg::REG_ENABLE:   cfg_reg.enable <= cfg_data[0];
                lrhm_pkg::REG_RATIO:    cfg_reg.busy_ratio_ppm <= cfg_data;
                lrhm_pkg::REG_WINDOW:   cfg_reg.window_ticks <= cfg_data[CW-1:0];
                lrhm_pkg::REG_HIGH_THR: cfg_reg.high_count_threshold <= cfg_data[CW-1:0];
                lrhm_pkg::REG_LOW_THR:  cfg_reg.low_count_threshold <= cfg_data[CW-1:0];
                default:                ;
            endcase
        end
    end

    // Turning monitoring off drops the window in progress.
    assign window_clear = cfg_we && !cfg_data[0]
                          && (cfg_index == lrhm_pkg::REG_ENABLE);

    // Credit counter: beats accepted but not yet popped.
    logic [CNT_W-1:0] in_flight_reg, in_flight_next;
    logic             in_accept, out_accept;

    assign full       = (in_flight_reg == CREDIT_MAX);
    assign in_accept  = push && !full;
    assign out_accept = pop && !empty;

    always_comb
    begin
        in_flight_next = in_flight_reg;
        if (in_accept && !out_accept)
        begin
            in_flight_next = in_flight_reg + 1'b1;
        end
        else if (out_accept && !in_accept)
        begin
            in_flight_next = in_flight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg <= '0;
        end
        else
        begin
            in_flight_reg <= in_flight_next;
        end
    end

    // Front: deltas, products and classification.
    logic                  class_valid;
    lrhm_pkg::tick_class_t class_data;

    lrhm_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (in_accept),
        .total_time_sample (total_time_sample),
        .busy_time_sample  (busy_time_sample),
        .cfg               (cfg_reg),
        .class_valid       (class_valid),
        .class_data        (class_data)
    );

    // Queue between the front and the back.
    logic                  mid_full, mid_empty, mid_pop;
    logic [CLASS_W-1:0]    mid_head;
    logic                  res_full;

    lrhm_fifo #(
        .WIDTH (CLASS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (class_valid),
        .push_data (class_data),
        .full      (mid_full),
        .pop       (mid_pop),
        .head_data (mid_head),
        .empty     (mid_empty)
    );

    assign mid_pop = !mid_empty && !res_full;

    // Back: window counters and hysteresis.
    lrhm_pkg::result_t back_result;

    lrhm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .window_clear (window_clear),
        .tick_valid   (mid_pop),
        .tick         (lrhm_pkg::tick_class_t'(mid_head)),
        .result       (back_result)
    );

    // Result queue.
    logic [RESULT_W-1:0] res_head;
    lrhm_pkg::result_t   res_item;

    lrhm_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_pop),
        .push_data (back_result),
        .full      (res_full),
        .pop       (out_accept),
        .head_data (res_head),
        .empty     (empty)
    );

    assign res_item      = lrhm_pkg::result_t'(res_head);
    assign report        = res_item.report;
    assign tick_was_high = res_item.tick_was_high;
    assign window_closed = res_item.window_closed;

    // With nothing in flight, neither queue may hold a beat.
    a_idle_queues_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_flight_reg == '0) |-> (empty && mid_empty && !mid_full))
        else $error("top: queues not empty with no beat in flight");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the load ratio hysteresis monitor
// Feeds cumulative total and busy time samples through the push/full side,
// predicts every result beat with an in-bench mirror of the window logic and
// compares each popped beat field by field. Covers disabled ticks, exact
// ratio boundaries, counter wrap, saturation and a spread of register settings under
// several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned SAMPLE_W   = lrhm_pkg::SAMPLE_W;
    localparam int unsigned RATIO_W    = lrhm_pkg::RATIO_W;
    localparam int unsigned COUNT_W    = lrhm_pkg::COUNT_W;
    localparam int unsigned CFG_IDX_W  = lrhm_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = lrhm_pkg::CFG_DATA_W;
    localparam int unsigned PROD_W     = lrhm_pkg::PROD_W;

    // A run counts as stuck once a stretch in which neither side moves a beat
    // reaches this limit. The longest legal quiet stretch is a register update
    // plus the drain pause.
    localparam int STALL_LIMIT  = 4000;
    // Drain pause that lets the pipeline run dry before registers are touched
    // or the run ends.
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 12;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [SAMPLE_W-1:0] total;
        logic [SAMPLE_W-1:0] busy;
    } tick_sample_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push  = 1'b0;
    logic                  full;
    logic [SAMPLE_W-1:0]   total_time_sample = '0;
    logic [SAMPLE_W-1:0]   busy_time_sample  = '0;
    logic                  empty;
    logic                  pop   = 1'b0;
    logic [1:0]            report;
    logic                  tick_was_high;
    logic                  window_closed;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always #10 clk = ~clk;

    load_ratio_hysteresis_monitor_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .total_time_sample (total_time_sample),
        .busy_time_sample  (busy_time_sample),
        .empty             (empty),
        .pop               (pop),
        .report            (report),
        .tick_was_high     (tick_was_high),
        .window_closed     (window_closed),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Mirror of the block: register copies and window state, all at the
    // widths the block uses so that 8-bit wrap falls out naturally.
    // ------------------------------------------------------------------------
    logic               cfg_enable   = 1'b0;
    logic [RATIO_W-1:0] cfg_ratio    = lrhm_pkg::RATIO_RESET;
    logic [COUNT_W-1:0] cfg_window   = lrhm_pkg::WINDOW_RESET;
    logic [COUNT_W-1:0] cfg_high_thr = lrhm_pkg::HIGH_THR_RESET;
    logic [COUNT_W-1:0] cfg_low_thr  = lrhm_pkg::LOW_THR_RESET;

    logic [SAMPLE_W-1:0] last_total    = '0;
    logic [SAMPLE_W-1:0] last_busy     = '0;
    logic [COUNT_W-1:0]  win_ticks     = '0;
    logic [COUNT_W-1:0]  win_high      = '0;
    logic                reported_high = 1'b0;

    // Bench bookkeeping.
    tick_sample_t        sample_queue[$];
    lrhm_pkg::result_t   expected_ticks[$];
    logic [SAMPLE_W-1:0] stim_total = '0;
    logic [SAMPLE_W-1:0] stim_busy  = '0;
    int send_idle_pct  = 0;
    int take_stall_pct = 0;
    int error_count    = 0;
    int beats_in       = 0;
    int beats_out      = 0;
    int windows_seen   = 0;
    int high_reports   = 0;
    int low_reports    = 0;
    int high_ticks     = 0;
    int quiet_cycles   = 0;

    // Classifies one tick against the mirrored state and advances it. The
    // two products are formed at 84 bits so nothing wraps before the compare.
    function automatic lrhm_pkg::result_t predict_tick(input logic [SAMPLE_W-1:0] total,
                                                       input logic [SAMPLE_W-1:0] busy);
        lrhm_pkg::result_t   outcome;
        logic [SAMPLE_W-1:0] total_delta;
        logic [SAMPLE_W-1:0] busy_delta;
        logic [PROD_W-1:0]   busy_scaled;
        logic [PROD_W-1:0]   limit_scaled;
        outcome.report        = lrhm_pkg::REPORT_NONE;
        outcome.tick_was_high = 1'b0;
        outcome.window_closed = 1'b0;
        if (!cfg_enable)
        begin
            // A disabled tick keeps the window empty and leaves the
            // previous samples alone.
            win_ticks = '0;
            win_high  = '0;
        end
        else
        begin
            total_delta = total - last_total;
            busy_delta  = busy - last_busy;
            if (total_delta != '0)
            begin
                busy_scaled  = PROD_W'(busy_delta) * PROD_W'(lrhm_pkg::PPM_SCALE);
                limit_scaled = PROD_W'(total_delta) * PROD_W'(cfg_ratio);
                if (busy_scaled >= limit_scaled)
                begin
                    outcome.tick_was_high = 1'b1;
                    if (win_high != lrhm_pkg::COUNT_MAX)
                        win_high = win_high + 8'd1;
                end
            end
            win_ticks = win_ticks + 8'd1;
            if (win_ticks == cfg_window)
            begin
                outcome.window_closed = 1'b1;
                // HIGH is tried first; LOW only after a HIGH was the last
                // report, so each report is a change.
                if (win_high >= cfg_high_thr && !reported_high)
                begin
                    outcome.report = lrhm_pkg::REPORT_HIGH;
                    reported_high  = 1'b1;
                end
                else if (win_high == cfg_low_thr && reported_high)
                begin
                    outcome.report = lrhm_pkg::REPORT_LOW;
                    reported_high  = 1'b0;
                end
                win_ticks = '0;
                win_high  = '0;
            end
            last_total = total;
            last_busy  = busy;
        end
        return outcome;
    endfunction

    function automatic bit chance(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h (result beat %0d)",
                 what, got, want, beats_out);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers. Samples are built from deltas on running counters so
    // that the block sees the ratio that was aimed for.
    // ------------------------------------------------------------------------
    task automatic queue_delta(input logic [SAMPLE_W-1:0] total_step,
                               input logic [SAMPLE_W-1:0] busy_step);
        stim_total = stim_total + total_step;
        stim_busy  = stim_busy + busy_step;
        sample_queue.push_back('{total: stim_total, busy: stim_busy});
    endtask

    task automatic queue_raw(input logic [SAMPLE_W-1:0] total,
                             input logic [SAMPLE_W-1:0] busy);
        stim_total = total;
        stim_busy  = busy;
        sample_queue.push_back('{total: total, busy: busy});
    endtask

    // Switches the idling pattern; done at a falling edge so that the change
    // never lands in the same step as a driver or monitor decision.
    task automatic set_idling(input idle_mode_t mode);
        @(negedge clk);
        send_idle_pct  = (mode == IDLE_SENDER)   ? 56 : (mode == IDLE_BOTH) ? 12 : 0;
        take_stall_pct = (mode == IDLE_RECEIVER) ? 56 : (mode == IDLE_BOTH) ? 12 : 0;
    endtask

    // Waits until every queued beat went in and every expected beat came
    // out, then lets the pipeline run dry.
    task automatic settle();
        while (sample_queue.size() != 0 || push || expected_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; the mirror follows the same masking rules. Only
    // called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            lrhm_pkg::REG_ENABLE:
            begin
                cfg_enable = data[0];
                if (!cfg_enable)
                begin
                    win_ticks = '0;
                    win_high  = '0;
                end
            end
            lrhm_pkg::REG_RATIO:    cfg_ratio    = data[RATIO_W-1:0];
            lrhm_pkg::REG_WINDOW:   cfg_window   = data[COUNT_W-1:0];
            lrhm_pkg::REG_HIGH_THR: cfg_high_thr = data[COUNT_W-1:0];
            lrhm_pkg::REG_LOW_THR:  cfg_low_thr  = data[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents the next pending sample, holds it while full is high,
    // and hands every accepted beat to the predictor.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        tick_sample_t beat;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                expected_ticks.push_back(predict_tick(total_time_sample,
                                                      busy_time_sample));
                beats_in++;
            end
            if (!(push && full))
            begin
                if (sample_queue.size() != 0 && !chance(send_idle_pct))
                begin
                    beat = sample_queue.pop_front();
                    push              <= 1'b1;
                    total_time_sample <= beat.total;
                    busy_time_sample  <= beat.busy;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: pops at random and checks each result beat against the
    // oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        lrhm_pkg::result_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_ticks.size() == 0)
                    report_mismatch("beat with nothing expected",
                                    64'({report, tick_was_high, window_closed}), '0);
                else
                begin
                    want = expected_ticks.pop_front();
                    if (report !== want.report)
                        report_mismatch("report", 64'(report), 64'(want.report));
                    if (tick_was_high !== want.tick_was_high)
                        report_mismatch("tick_was_high", 64'(tick_was_high),
                                        64'(want.tick_was_high));
                    if (window_closed !== want.window_closed)
                        report_mismatch("window_closed", 64'(window_closed),
                                        64'(want.window_closed));
                end
                beats_out++;
                windows_seen += (window_closed === 1'b1);
                high_ticks   += (tick_was_high === 1'b1);
                high_reports += (report === lrhm_pkg::REPORT_HIGH);
                low_reports  += (report === lrhm_pkg::REPORT_LOW);
            end
            pop <= !chance(take_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which no beat moves on either side.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed ticks, then randomized phases, each with
    // its own register setting and idling pattern.
    // ------------------------------------------------------------------------
    initial
    begin
        logic                  en;
        logic [RATIO_W-1:0]    ratio;
        logic [COUNT_W-1:0]    window;
        logic [COUNT_W-1:0]    hi_thr;
        logic [COUNT_W-1:0]    lo_thr;
        logic [CFG_IDX_W-1:0]  bad_index;
        logic [SAMPLE_W-1:0]   td;
        logic [SAMPLE_W-1:0]   meet;
        logic [PROD_W-1:0]     scaled;
        int                    n_items;
        int                    kind;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block comes out of reset disabled, so the first
        // two beats must produce all-zero results and leave the previous
        // samples at zero.
        set_idling(IDLE_BOTH);
        queue_raw('1, '1);
        queue_raw('0, '1);
        settle();
        write_reg(lrhm_pkg::REG_ENABLE, 20'd1);
        // An index past the last register must change nothing.
        write_reg(CFG_IDX_W'(lrhm_pkg::REG_LOW_THR) + 3'd1, '1);
        set_idling(IDLE_NONE);

        // First window (length five): zero total delta, then four high ticks
        // including an exact ratio hit, full-scale deltas and a busy counter
        // that wraps. Four reaches the threshold, so HIGH is reported.
        queue_raw(64'd0, 64'd5);
        queue_delta(64'd1000000, 64'd980000);
        queue_delta('1, '1);
        queue_delta(64'd10, '1);
        queue_delta(64'd1000000, 64'd980000);
        // Second window: one short of the ratio, full total with no busy,
        // zero delta, and a single high tick, so no report.
        queue_delta(64'd1000000, 64'd979999);
        queue_delta('1, 64'd0);
        queue_delta(64'd0, 64'd7);
        queue_delta(64'd1, 64'd0);
        queue_delta(64'd1, 64'd1);
        // Third window has no high tick and matches the low threshold.
        repeat (5) queue_delta(64'd1000, 64'd0);
        // Two high ticks, then clearing enable empties the window, so five
        // more high ticks are needed before the next close.
        repeat (2) queue_delta(64'd5, 64'd5);
        settle();
        write_reg(lrhm_pkg::REG_ENABLE, 20'd0);
        write_reg(lrhm_pkg::REG_ENABLE, 20'd1);
        set_idling(IDLE_RECEIVER);
        repeat (5) queue_delta(64'd5, 64'd5);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            n_items = $urandom_range(30, 55);
            case (phase)
                0:
                begin
                    en = 1'b1; ratio = lrhm_pkg::RATIO_RESET;
                    window = lrhm_pkg::WINDOW_RESET;
                    hi_thr = lrhm_pkg::HIGH_THR_RESET; lo_thr = lrhm_pkg::LOW_THR_RESET;
                end
                1:
                begin
                    en = 1'b1; ratio = '0; window = 8'd1; hi_thr = '0; lo_thr = '0;
                end
                2:
                begin
                    en = 1'b1; ratio = 20'd1000000; window = 8'd255;
                    hi_thr = lrhm_pkg::COUNT_MAX; lo_thr = lrhm_pkg::COUNT_MAX;
                end
                3:
                begin
                    // Ratio above one million is taken as written.
                    en = 1'b1; ratio = '1; window = 8'($urandom_range(1, 8));
                    hi_thr = 8'($urandom_range(0, 3)); lo_thr = 8'($urandom_range(0, 3));
                end
                5:
                begin
                    // A 256-tick window of high ticks drives the high count
                    // into saturation at 255.
                    en = 1'b1; ratio = '0; window = '0;
                    hi_thr = lrhm_pkg::COUNT_MAX; lo_thr = lrhm_pkg::COUNT_MAX;
                    n_items = 260;
                    write_reg(lrhm_pkg::REG_ENABLE, 20'd0);
                end
                default:
                begin
                    en = (phase == 4) ? 1'b0 : ($urandom_range(0, 5) != 0);
                    case ($urandom_range(0, 3))
                        0: ratio = lrhm_pkg::RATIO_RESET - 20'd20000
                                   + 20'($urandom_range(0, 40000));
                        1: ratio = 20'($urandom);
                        2: ratio = 20'($urandom_range(0, 1000000));
                        default: ratio = 20'd500000;
                    endcase
                    window = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(1, 8));
                    hi_thr = 8'($urandom_range(0, int'(window) + 1));
                    lo_thr = 8'($urandom_range(0, int'(window)));
                end
            endcase

            // Narrow registers get junk in the unused upper data bits.
            write_reg(lrhm_pkg::REG_ENABLE,   {19'($urandom), en});
            write_reg(lrhm_pkg::REG_RATIO,    ratio);
            write_reg(lrhm_pkg::REG_WINDOW,   {12'($urandom), window});
            write_reg(lrhm_pkg::REG_HIGH_THR, {12'($urandom), hi_thr});
            write_reg(lrhm_pkg::REG_LOW_THR,  {12'($urandom), lo_thr});
            bad_index = CFG_IDX_W'(lrhm_pkg::REG_LOW_THR) + 3'($urandom_range(1, 3));
            write_reg(bad_index, 20'($urandom));
            set_idling(idle_mode_t'(phase % 4));

            for (int i = 0; i < n_items; i++)
            begin
                kind = $urandom_range(99, 0);
                if (phase == 5)
                    queue_delta(64'($urandom_range(1, 1000)), {$urandom, $urandom});
                else if (kind < 65)
                begin
                    // Well-formed tick aimed at the ratio boundary: the
                    // smallest busy delta that still counts as high, one
                    // below it, a bit above it, or a small busy share.
                    case ($urandom_range(0, 2))
                        0: td = 64'($urandom_range(1, 2000000));
                        1: td = {$urandom, $urandom};
                        default: td = '1 - 64'($urandom_range(0, 1000));
                    endcase
                    scaled = PROD_W'(td) * PROD_W'(cfg_ratio);
                    scaled = (scaled + PROD_W'(lrhm_pkg::PPM_SCALE) - 84'd1)
                             / PROD_W'(lrhm_pkg::PPM_SCALE);
                    meet   = scaled[SAMPLE_W-1:0];
                    case ($urandom_range(0, 4))
                        0, 1: queue_delta(td, meet);
                        2: queue_delta(td, meet - 64'd1);
                        3: queue_delta(td, meet + 64'($urandom_range(1, 1000)));
                        default: queue_delta(td, td >> $urandom_range(0, 8));
                    endcase
                end
                else if (kind < 75)
                    queue_delta(64'd0, {$urandom, $urandom});
                else if (kind < 95)
                    queue_raw({$urandom, $urandom}, {$urandom, $urandom});
                else
                    queue_raw($urandom_range(0, 1) ? '1 : '0,
                              $urandom_range(0, 1) ? '1 : '0);
            end
        end

        settle();
        $display("Run moved %0d beats in and %0d out over %0d register phases.",
                 beats_in, beats_out, PHASES);
        $display("Seen %0d high ticks, %0d closed windows, %0d HIGH and %0d LOW reports.",
                 high_ticks, windows_seen, high_reports, low_reports);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/lrhm_pkg.sv
rtl/lrhm_fifo.sv
rtl/lrhm_front.sv
rtl/lrhm_back.sv
rtl/load_ratio_hysteresis_monitor_top.sv
sim/tb_top.sv
